// File: design/hcd_pkg.sv
package hcd_pkg;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZERO   = 3'd2,
      PH_XPFX   = 3'd3,
      PH_DIGITS = 3'd4,
      PH_DATA   = 3'd5,
      PH_TRAIL  = 3'd6,
      PH_END    = 3'd7
   } phase_type;

   localparam logic [1:0] STATUS_RUN  = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // trailing pair after the chunk data
   localparam int TRAIL_LEN = 2;

   // classified input request
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_space;
      logic       is_plus;
      logic       is_minus;
      logic       is_zero;
      logic       is_x;
      logic       is_cr;
      logic       is_lf;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] status;
   } result_type;

endpackage

// File: design/hcd_fifo.sv
module hcd_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] rdata,
   output logic             empty
);

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits = $clog2(Depth + 1);

   logic [Width-1:0]   mem_ff [Depth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CntBits'(Depth));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: design/hcd_front.sv
module hcd_front (
   input  logic              in_byte_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              queue_full,
   output logic              queue_push,
   output hcd_pkg::item_type item
);

   assign queue_push = in_byte_valid & ~queue_full;

   always_comb begin
      item          = '0;
      item.data     = in_byte;
      item.last     = in_last;
      item.is_space = (in_byte == hcd_pkg::CHAR_SPACE) ||
                      (in_byte >= hcd_pkg::CHAR_TAB && in_byte <= hcd_pkg::CHAR_CR);
      item.is_plus  = (in_byte == hcd_pkg::CHAR_PLUS);
      item.is_minus = (in_byte == hcd_pkg::CHAR_MINUS);
      item.is_zero  = (in_byte == hcd_pkg::CHAR_ZERO);
      item.is_x     = (in_byte == hcd_pkg::CHAR_LOW_X) || (in_byte == hcd_pkg::CHAR_UP_X);
      item.is_cr    = (in_byte == hcd_pkg::CHAR_CR);
      item.is_lf    = (in_byte == hcd_pkg::CHAR_LF);
      case (in_byte) inside
         ["0":"9"]: begin
            item.is_hex  = 1'b1;
            item.hex_val = in_byte[3:0];
         end
         ["a":"f"], ["A":"F"]: begin
            item.is_hex  = 1'b1;
            item.hex_val = in_byte[3:0] + 4'd9;
         end
         default: begin
            item.is_hex  = 1'b0;
            item.hex_val = '0;
         end
      endcase
   end

endmodule

// File: design/hcd_back.sv
module hcd_back #(
   parameter int SizeBits = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_ready,
   input  hcd_pkg::item_type   item,
   output logic                item_pop,
   input  logic                rsp_full,
   output logic                rsp_push,
   output hcd_pkg::result_type rsp
);

   hcd_pkg::phase_type  phase_ff, phase_in;
   logic [SizeBits-1:0] count_ff, count_in;
   logic                crp_ff, crp_in;
   logic                neg_ff, neg_in;
   logic                ds_ff, ds_in;
   logic                ds_v;
   logic                fire;

   assign fire     = item_ready & ~rsp_full;
   assign item_pop = fire;
   assign rsp_push = fire;

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      crp_in   = crp_ff;
      neg_in   = neg_ff;
      ds_in    = ds_ff;
      ds_v     = ds_ff;
      case (phase_ff)
         hcd_pkg::PH_END: begin
         end
         hcd_pkg::PH_DATA: begin
            if (count_ff <= SizeBits'(1)) begin
               phase_in = hcd_pkg::PH_TRAIL;
               count_in = SizeBits'(hcd_pkg::TRAIL_LEN);
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         hcd_pkg::PH_TRAIL: begin
            if (count_ff <= SizeBits'(1)) begin
               phase_in = hcd_pkg::PH_LEAD;
               count_in = '0;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            if (crp_ff && item.is_lf) begin
               crp_in = 1'b0;
               neg_in = 1'b0;
               ds_in  = 1'b0;
               if (count_ff == '0) begin
                  phase_in = hcd_pkg::PH_END;
                  count_in = SizeBits'(hcd_pkg::STATUS_DONE);
               end else if (neg_ff) begin
                  phase_in = hcd_pkg::PH_END;
                  count_in = SizeBits'(hcd_pkg::STATUS_BAD);
               end else begin
                  phase_in = hcd_pkg::PH_DATA;
               end
            end else begin
               // a held CR that did not open CR LF is plain whitespace
               if (crp_ff && phase_ff != hcd_pkg::PH_LEAD) begin
                  ds_v = 1'b1;
               end
               crp_in = 1'b0;
               ds_in  = ds_v;
               if (item.is_cr) begin
                  crp_in = 1'b1;
               end else if (!ds_v) begin
                  if (phase_ff == hcd_pkg::PH_LEAD && item.is_space) begin
                  end else if (phase_ff == hcd_pkg::PH_LEAD &&
                               (item.is_plus || item.is_minus)) begin
                     neg_in   = neg_ff | item.is_minus;
                     phase_in = hcd_pkg::PH_SIGNED;
                  end else if ((phase_ff == hcd_pkg::PH_LEAD ||
                                phase_ff == hcd_pkg::PH_SIGNED) && item.is_zero) begin
                     phase_in = hcd_pkg::PH_ZERO;
                  end else if (phase_ff == hcd_pkg::PH_ZERO && item.is_x) begin
                     phase_in = hcd_pkg::PH_XPFX;
                  end else if (item.is_hex) begin
                     if (count_ff[SizeBits-1 -: 4] != 4'd0) begin
                        phase_in = hcd_pkg::PH_END;
                        count_in = SizeBits'(hcd_pkg::STATUS_BAD);
                        crp_in   = 1'b0;
                        neg_in   = 1'b0;
                        ds_in    = 1'b0;
                     end else begin
                        count_in = {count_ff[SizeBits-5:0], item.hex_val};
                        phase_in = hcd_pkg::PH_DIGITS;
                     end
                  end else begin
                     ds_in = 1'b1;
                  end
               end
            end
         end
      endcase
   end

   // result
   always_comb begin
      rsp            = '0;
      rsp.out_byte   = (phase_ff == hcd_pkg::PH_DATA) ? item.data : 8'd0;
      rsp.byte_valid = (phase_ff == hcd_pkg::PH_DATA);
      if (phase_in == hcd_pkg::PH_END) begin
         rsp.status = count_in[1:0];
      end else if (item.last) begin
         rsp.status = hcd_pkg::STATUS_BAD;
      end else begin
         rsp.status = hcd_pkg::STATUS_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && item.last)) begin
         phase_ff <= hcd_pkg::PH_LEAD;
         count_ff <= '0;
         crp_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         ds_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crp_ff   <= crp_in;
         neg_ff   <= neg_in;
         ds_ff    <= ds_in;
      end
   end

endmodule

// File: design/http_chunked_decoder.sv
// HTTP chunked body decoder. Raw body bytes enter through a queue-style port
// (push/full) and one result per byte leaves through another (empty/pop), in
// order. Sustained rate is one byte per clock while neither queue is full; each
// request is registered in the input queue, and the back end reads the head of
// the input queue, updates size and phase and writes the output queue in that
// same cycle. Data bytes stream out with byte_valid set before the chunk is
// known to be well formed, so a consumer drops them when status reports
// malformed. last_byte returns the decoder to its start state. SIZE_BITS sets
// the widest chunk size accepted.
module http_chunked_decoder #(
   parameter int SIZE_BITS  = 32,
   parameter int FIFO_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic [1:0] rsp_status
);

   hcd_pkg::item_type   front_item, back_item;
   hcd_pkg::result_type back_rsp, out_rsp;
   logic                front_push;
   logic                mid_empty, mid_pop;
   logic                out_full, out_push;

   hcd_front u_front (
      .in_byte_valid (push),
      .in_byte       (req_in_byte),
      .in_last       (req_last_byte),
      .queue_full    (full),
      .queue_push    (front_push),
      .item          (front_item)
   );

   hcd_fifo #(
      .Width ($bits(hcd_pkg::item_type)),
      .Depth (FIFO_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_item),
      .full  (full),
      .pop   (mid_pop),
      .rdata (back_item),
      .empty (mid_empty)
   );

   hcd_back #(
      .SizeBits (SIZE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_ready (~mid_empty),
      .item       (back_item),
      .item_pop   (mid_pop),
      .rsp_full   (out_full),
      .rsp_push   (out_push),
      .rsp        (back_rsp)
   );

   hcd_fifo #(
      .Width ($bits(hcd_pkg::result_type)),
      .Depth (FIFO_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rsp),
      .empty (empty)
   );

   assign rsp_out_byte   = out_rsp.out_byte;
   assign rsp_byte_valid = out_rsp.byte_valid;
   assign rsp_status     = out_rsp.status;

`ifndef NO_ASSERTIONS
   a_one_result_per_request: assert property (@(posedge clock) disable iff (reset)
      mid_pop == out_push) else $error("back end consumed a request without a result");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("result pushed into a full queue");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_status <= hcd_pkg::STATUS_BAD) else $error("undefined status code");

   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> empty && mid_empty)
      else $error("queues not empty after reset");
`endif

endmodule

// File: sim/http_chunked_decoder_tb.sv
module http_chunked_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIZE_BITS = 32;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int DRAIN_AT = 180;
   localparam int ITEM_COUNT = 550;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } body_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic [1:0] rsp_status;

   body_byte_type       body_stream[$];
   hcd_pkg::result_type decoded_bytes[$];
   hcd_pkg::result_type want;

   int total_items = 0;
   int error_count = 0;
   int result_count = 0;
   int payload_count = 0;
   int done_count = 0;
   int bad_count = 0;
   int cycle_count = 0;

   // decoder state as the block should hold it
   hcd_pkg::phase_type   dec_phase = hcd_pkg::PH_LEAD;
   logic [SIZE_BITS-1:0] dec_count = '0;
   logic                 dec_cr = 1'b0;
   logic                 dec_neg = 1'b0;
   logic                 dec_stop = 1'b0;

   http_chunked_decoder #(.SIZE_BITS(SIZE_BITS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_in_byte    (req_in_byte),
      .req_last_byte  (req_last_byte),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == hcd_pkg::CHAR_SPACE ||
             (c >= hcd_pkg::CHAR_TAB && c <= hcd_pkg::CHAR_CR);
   endfunction

   function automatic void clear_decoder();
      dec_phase = hcd_pkg::PH_LEAD;
      dec_count = '0;
      dec_cr = 1'b0;
      dec_neg = 1'b0;
      dec_stop = 1'b0;
   endfunction

   function automatic void close_body(input logic [1:0] code);
      clear_decoder();
      dec_phase = hcd_pkg::PH_END;
      dec_count = SIZE_BITS'(code);
   endfunction

   function automatic bit shift_digit(input logic [3:0] d);
      if ((dec_count >> (SIZE_BITS - 4)) != 0) return 1'b0;
      dec_count = {dec_count[SIZE_BITS-5:0], d};
      dec_phase = hcd_pkg::PH_DIGITS;
      return 1'b1;
   endfunction

   // one size line character; returns 0 on size overflow
   function automatic bit scan_size_char(input logic [7:0] c);
      int h;
      h = hex_value(c);
      if (dec_stop) return 1'b1;
      if (dec_phase == hcd_pkg::PH_LEAD) begin
         if (is_blank(c)) return 1'b1;
         if (c == hcd_pkg::CHAR_PLUS || c == hcd_pkg::CHAR_MINUS) begin
            if (c == hcd_pkg::CHAR_MINUS) dec_neg = 1'b1;
            dec_phase = hcd_pkg::PH_SIGNED;
            return 1'b1;
         end
      end
      if (dec_phase == hcd_pkg::PH_LEAD || dec_phase == hcd_pkg::PH_SIGNED) begin
         if (c == hcd_pkg::CHAR_ZERO) begin
            dec_phase = hcd_pkg::PH_ZERO;
            return 1'b1;
         end
      end else if (dec_phase == hcd_pkg::PH_ZERO &&
                   (c == hcd_pkg::CHAR_LOW_X || c == hcd_pkg::CHAR_UP_X)) begin
         dec_phase = hcd_pkg::PH_XPFX;
         return 1'b1;
      end
      if (h >= 0) return shift_digit(h[3:0]);
      dec_stop = 1'b1;
      return 1'b1;
   endfunction

   function automatic void end_size_line();
      logic [SIZE_BITS-1:0] size;
      logic                 minus;
      size = dec_count;
      minus = dec_neg;
      dec_cr = 1'b0;
      dec_neg = 1'b0;
      dec_stop = 1'b0;
      if (size == 0) close_body(hcd_pkg::STATUS_DONE);
      else if (minus) close_body(hcd_pkg::STATUS_BAD);
      else dec_phase = hcd_pkg::PH_DATA;
   endfunction

   function automatic hcd_pkg::result_type decode_byte(input logic [7:0] c,
                                                       input logic last);
      hcd_pkg::result_type r;
      bit                  ok;
      r = '0;
      case (dec_phase)
         hcd_pkg::PH_END: ;
         hcd_pkg::PH_DATA: begin
            r.out_byte = c;
            r.byte_valid = 1'b1;
            if (dec_count <= 1) begin
               dec_phase = hcd_pkg::PH_TRAIL;
               dec_count = SIZE_BITS'(hcd_pkg::TRAIL_LEN);
            end else dec_count = dec_count - 1;
         end
         hcd_pkg::PH_TRAIL: begin
            if (dec_count <= 1) begin
               dec_phase = hcd_pkg::PH_LEAD;
               dec_count = '0;
            end else dec_count = dec_count - 1;
         end
         default: begin
            if (dec_cr && c == hcd_pkg::CHAR_LF) begin
               end_size_line();
            end else begin
               ok = 1'b1;
               if (dec_cr) begin
                  dec_cr = 1'b0;
                  ok = scan_size_char(hcd_pkg::CHAR_CR);
               end
               if (ok) begin
                  if (c == hcd_pkg::CHAR_CR) dec_cr = 1'b1;
                  else ok = scan_size_char(c);
               end
               if (!ok) close_body(hcd_pkg::STATUS_BAD);
            end
         end
      endcase
      r.status = (dec_phase == hcd_pkg::PH_END) ? dec_count[1:0] : hcd_pkg::STATUS_RUN;
      if (last) begin
         if (dec_phase != hcd_pkg::PH_END) r.status = hcd_pkg::STATUS_BAD;
         clear_decoder();
      end
      return r;
   endfunction

   // ---------------- stimulus ----------------

   task automatic put(input logic [7:0] b);
      body_byte_type item;
      item.data = b;
      item.last = 1'b0;
      body_stream = {body_stream, item};
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   task automatic put_crlf();
      put(hcd_pkg::CHAR_CR);
      put(hcd_pkg::CHAR_LF);
   endtask

   task automatic put_junk(input int n);
      repeat (n) put(8'($urandom_range(0, 255)));
   endtask

   task automatic mark_last();
      body_stream[body_stream.size() - 1].last = 1'b1;
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] d);
      if (d < 10) return hcd_pkg::CHAR_ZERO + d;
      return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return hcd_pkg::CHAR_SPACE;
         1: return hcd_pkg::CHAR_TAB;
         2: return 8'h0b;
         3: return 8'h0c;
         4: return hcd_pkg::CHAR_LF;
         default: return hcd_pkg::CHAR_CR;
      endcase
   endfunction

   // ndig of 0 picks the minimal digit count
   task automatic put_size_line(input logic [63:0] size, input int ndig, input bit minus);
      int n;
      n = ndig;
      if (n == 0) begin
         n = 1;
         while (n < 16 && (size >> (4 * n)) != 0) n++;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(blank_char());
      if (minus) put(hcd_pkg::CHAR_MINUS);
      else if ($urandom_range(0, 7) == 0) put(hcd_pkg::CHAR_PLUS);
      if ($urandom_range(0, 3) == 0) begin
         put(hcd_pkg::CHAR_ZERO);
         put($urandom_range(0, 1) ? hcd_pkg::CHAR_LOW_X : hcd_pkg::CHAR_UP_X);
      end
      if ($urandom_range(0, 5) == 0) put(hcd_pkg::CHAR_ZERO);
      for (int i = n - 1; i >= 0; i--) put(hex_digit(size[4*i +: 4]));
      if ($urandom_range(0, 3) == 0) begin
         put(";");
         repeat ($urandom_range(0, 4)) put(8'($urandom_range(8'h21, 8'h7e)));
      end
      put_crlf();
   endtask

   task automatic put_body();
      int          kind;
      int          start;
      int          size;
      int          ndig;
      int          cut;
      logic [63:0] wide;
      kind = $urandom_range(0, 99);
      start = body_stream.size();
      if (kind < 70) begin
         repeat ($urandom_range(0, 3)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            put_size_line(64'(size), 0, 1'b0);
            repeat (size) put(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0) begin
               put(8'($urandom_range(0, 255)));
               put(8'($urandom_range(0, 255)));
            end else put_crlf();
         end
         put_size_line(64'd0, $urandom_range(1, 2), $urandom_range(0, 5) == 0);
         put_junk($urandom_range(0, 2));
         if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(start, body_stream.size() - 1);
            while (body_stream.size() > cut + 1) void'(body_stream.pop_back());
         end
      end else if (kind < 78) begin
         put_size_line(64'($urandom_range(1, 255)), 0, 1'b1);
         put_junk($urandom_range(0, 3));
      end else if (kind < 85) begin
         ndig = $urandom_range(9, 11);
         wide = {$urandom, $urandom};
         wide[4*(ndig-1) +: 4] = 4'($urandom_range(1, 15));
         put_size_line(wide, ndig, 1'b0);
      end else if (kind < 92) begin
         case ($urandom_range(0, 4))
            0: put_text("x");
            1: put_text("+");
            2: put_text("-");
            3: put_text("0x");
            default: put_text(";a");
         endcase
         put_crlf();
      end else begin
         repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
      end
      mark_last();
   endtask

   function automatic int sent_items();
      return total_items - body_stream.size();
   endfunction

   function automatic int sender_idle_pct();
      if (sent_items() < total_items / 3) return 19;
      if (sent_items() < 2 * total_items / 3) return 55;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (sent_items() < total_items / 3) return 55;
      if (sent_items() < 2 * total_items / 3) return 19;
      return 0;
   endfunction

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         req_in_byte <= 8'h00;
         req_last_byte <= 1'b0;
      end else begin
         if (push && !full) decoded_bytes = {decoded_bytes,
                                             decode_byte(req_in_byte, req_last_byte)};
         if (!push || !full) begin
            if (body_stream.size() != 0
                && !(sent_items() == DRAIN_AT && decoded_bytes.size() != 0)
                && $urandom_range(0, 99) >= sender_idle_pct()) begin
               req_in_byte <= body_stream[0].data;
               req_last_byte <= body_stream[0].last;
               void'(body_stream.pop_front());
               push <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ---------------- response monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (decoded_bytes.size() == 0) begin
               $error("response with no request outstanding: out_byte %h status %0d",
                      rsp_out_byte, rsp_status);
               error_count++;
            end else begin
               want = decoded_bytes.pop_front();
               result_count++;
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
                  error_count++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, got %b", want.byte_valid, rsp_byte_valid);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (want.byte_valid) payload_count++;
               if (want.status == hcd_pkg::STATUS_DONE) done_count++;
               if (want.status == hcd_pkg::STATUS_BAD) bad_count++;
            end
         end
         pop <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, decoded_bytes.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      // no digits at all: size zero
      put_crlf();
      mark_last();
      // negative zero
      put_text("-0");
      put_crlf();
      mark_last();
      // negative nonzero size
      put_text("-1");
      put_crlf();
      mark_last();
      // body cut short on a data byte
      put_text("1");
      put_crlf();
      put(8'hff);
      mark_last();
      // byte after completion is ignored
      put_text("0");
      put_crlf();
      put(8'h00);
      mark_last();
      // lone CR as blank, then 0x with no digits
      put(hcd_pkg::CHAR_SPACE);
      put(hcd_pkg::CHAR_CR);
      put_text("0x");
      put_crlf();
      mark_last();

      while (body_stream.size() < ITEM_COUNT) put_body();
      total_items = body_stream.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (body_stream.size() != 0 || push) @(posedge clock);
      while (decoded_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests decoded: %0d payload bytes, %0d bodies complete, %0d malformed",
               result_count, payload_count, done_count, bad_count);
      $display("covered blank/sign/0x size lines, extensions, overflow, early end and stalls");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/hcd_pkg.sv
design/hcd_fifo.sv
design/hcd_front.sv
design/hcd_back.sv
design/http_chunked_decoder.sv
sim/http_chunked_decoder_tb.sv
